>>> src/brf_pkg.sv
// Shared constants, codes and the queue entry type for the byte ring FIFO.
package brf_pkg;

	localparam int DEPTH    = 1024;
	localparam int MAX_TAKE = 64;

	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int LIMIT_W  = 11;
	localparam int WLEN_W   = 11;
	localparam int TLEN_W   = 7;
	localparam int FILL_W   = 11;
	localparam int TAKE_W   = $clog2(MAX_TAKE + 1);
	localparam int WIDE_W   = ((CNT_W > WLEN_W) ? CNT_W : WLEN_W) + 1;

	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_GIVE  = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_TAKE  = 2'd2;
	localparam logic [1:0] OP_RESET = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_BIG   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        data;
		logic              first;
		logic              last;
		logic              big;
		logic [WLEN_W-1:0] wlen;
		logic [TAKE_W-1:0] tlen;
	} brf_item_t;

endpackage

>>> src/brf_front.sv
// Front end: accepts command beats, classifies them and queues them for the back end.
module brf_front import brf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  logic             last_byte_in,
	input  logic [WLEN_W-1:0] write_length,
	input  logic [TLEN_W-1:0] take_length,
	input  logic [CNT_W-1:0] lim,
	output brf_item_t        head,
	output logic             head_valid,
	input  logic             pop
);

	brf_item_t               q_mem [QDEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       cnt_q;
	logic                    push;
	logic                    do_pop;
	brf_item_t               item;

	assign busy       = (cnt_q == QCNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = q_mem[rd_ptr_q];

	always_comb begin
		item.op    = opcode;
		item.data  = data_byte;
		item.first = first_byte;
		item.last  = last_byte_in;
		item.wlen  = write_length;
		item.big   = (WIDE_W'(write_length) > WIDE_W'(lim));
		if (take_length == '0) begin
			item.tlen = TAKE_W'(1);
		end else if (int'(take_length) > MAX_TAKE) begin
			item.tlen = TAKE_W'(MAX_TAKE);
		end else begin
			item.tlen = TAKE_W'(take_length);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/brf_back.sv
// Back end: ring state, byte store and result generation.
module brf_back import brf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  lim,
	input  logic              cfg_clear,
	input  brf_item_t         head,
	input  logic              head_valid,
	output logic              pop,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [7:0]        out_byte,
	output logic              last_result,
	output logic [FILL_W-1:0] fill_count
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DROP  = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;
	localparam logic [1:0] S_TAKE  = 2'd3;

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_s1;

	logic [1:0]        state_q, state_d;
	logic [PTR_W-1:0]  rp_q, rp_d;
	logic [PTR_W-1:0]  wp_q, wp_d;
	logic [CNT_W-1:0]  held_q, held_d;
	logic [1:0]        verdict_q, verdict_d;
	logic [CNT_W-1:0]  drop_q, drop_d;
	logic [TAKE_W-1:0] rem_q, rem_d;

	logic              valid_s1, valid_d;
	logic [1:0]        status_s1, status_d;
	logic              last_s1, last_d;
	logic              take_s1, take_d;
	logic [CNT_W-1:0]  fill_s1;

	logic              do_wr;
	logic              mem_we;
	logic              full_now;
	logic [WIDE_W-1:0] sum;
	logic [CNT_W:0]    rp_sum;

	function automatic logic [PTR_W-1:0] adv_one(input logic [PTR_W-1:0] p,
	                                             input logic [CNT_W-1:0] l);
		logic [CNT_W-1:0] q;
		q = CNT_W'(p) + CNT_W'(1);
		return (q >= l) ? '0 : PTR_W'(q);
	endfunction

	assign full_now = (held_q >= lim);
	assign sum      = WIDE_W'(held_q) + WIDE_W'(head.wlen);
	assign rp_sum   = (CNT_W+1)'(rp_q) + (CNT_W+1)'(drop_q);

	always_comb begin
		state_d   = state_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		held_d    = held_q;
		verdict_d = verdict_q;
		drop_d    = drop_q;
		rem_d     = rem_q;
		valid_d   = 1'b0;
		status_d  = STAT_OK;
		last_d    = 1'b1;
		take_d    = 1'b0;
		pop       = 1'b0;
		do_wr     = 1'b0;
		mem_we    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						OP_RESET: begin
							rp_d      = '0;
							wp_d      = '0;
							held_d    = '0;
							verdict_d = STAT_OK;
							valid_d   = 1'b1;
							pop       = 1'b1;
						end
						OP_TAKE: begin
							if (held_q == '0) begin
								valid_d  = 1'b1;
								status_d = STAT_EMPTY;
								pop      = 1'b1;
							end else begin
								rem_d   = head.tlen;
								state_d = S_TAKE;
							end
						end
						default: begin
							if (head.first) begin
								state_d = S_WRITE;
								if (head.big) begin
									verdict_d = STAT_BIG;
								end else if (head.op == OP_GIVE) begin
									verdict_d = (sum > WIDE_W'(lim)) ? STAT_FULL : STAT_OK;
								end else begin
									verdict_d = STAT_OK;
									if (sum > WIDE_W'(lim)) begin
										drop_d  = CNT_W'(sum - WIDE_W'(lim));
										state_d = S_DROP;
									end
								end
							end else begin
								do_wr = 1'b1;
							end
						end
					endcase
				end
			end
			S_DROP: begin
				rp_d    = (rp_sum >= (CNT_W+1)'(lim)) ? PTR_W'(rp_sum - (CNT_W+1)'(lim))
				                                       : PTR_W'(rp_sum);
				held_d  = held_q - drop_q;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				do_wr   = 1'b1;
				state_d = S_IDLE;
			end
			S_TAKE: begin
				rp_d    = adv_one(rp_q, lim);
				held_d  = held_q - CNT_W'(1);
				rem_d   = rem_q - TAKE_W'(1);
				valid_d = 1'b1;
				take_d  = 1'b1;
				last_d  = (rem_q == TAKE_W'(1)) || (held_q == CNT_W'(1));
				if (last_d) begin
					pop     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (do_wr) begin
			pop      = 1'b1;
			valid_d  = 1'b1;
			status_d = verdict_q;
			if (verdict_q == STAT_OK) begin
				if (full_now && head.op == OP_GIVE) begin
					status_d = STAT_FULL;
				end else begin
					mem_we = 1'b1;
					wp_d   = adv_one(wp_q, lim);
					if (full_now) begin
						rp_d = adv_one(rp_q, lim);
					end else begin
						held_d = held_q + CNT_W'(1);
					end
				end
			end
			if (head.last) begin
				verdict_d = STAT_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= head.data;
		end
		rd_data_s1 <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			held_q    <= '0;
			verdict_q <= STAT_OK;
			drop_q    <= '0;
			rem_q     <= '0;
			valid_s1  <= 1'b0;
			status_s1 <= STAT_OK;
			last_s1   <= 1'b0;
			take_s1   <= 1'b0;
			fill_s1   <= '0;
		end else if (cfg_clear) begin
			state_q   <= S_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			held_q    <= '0;
			verdict_q <= STAT_OK;
			valid_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rp_q      <= rp_d;
			wp_q      <= wp_d;
			held_q    <= held_d;
			verdict_q <= verdict_d;
			drop_q    <= drop_d;
			rem_q     <= rem_d;
			valid_s1  <= valid_d;
			status_s1 <= status_d;
			last_s1   <= last_d;
			take_s1   <= take_d;
			fill_s1   <= held_d;
		end
	end

	assign strobe      = valid_s1;
	assign status      = status_s1;
	assign last_result = last_s1;
	assign out_byte    = take_s1 ? rd_data_s1 : 8'd0;
	assign fill_count  = FILL_W'(fill_s1);

	a_held_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= lim) else $error("held count above limit");

	a_rp_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(rp_q) < lim) else $error("read pointer outside ring");

	a_wp_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(wp_q) < lim) else $error("write pointer outside ring");

	a_take_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAKE && !cfg_clear) |=> (valid_s1 && take_s1))
		else $error("take cycle without result beat");

endmodule

>>> src/byte_ring_fifo_atomic_messages_top.sv
// Flow: a command beat is queued in the front end and handled from the queue head by the
// back end. A reset, an empty take or a non-first write byte is handled in S_IDLE; a first
// write byte passes through S_WRITE, after S_DROP when a push drops old bytes; a take emits
// one byte per cycle in S_TAKE. Strobe, status and the byte are registered before output.
// A two-entry command queue sits between front and back; busy is high while it is full.
// Reset clears pointers, count, verdict, queue; limit back to 1024, store kept.
module byte_ring_fifo_atomic_messages_top import brf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               last_byte_in,
	input  logic [WLEN_W-1:0]  write_length,
	input  logic [TLEN_W-1:0]  take_length,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [7:0]         out_byte,
	output logic               last_result,
	output logic [FILL_W-1:0]  fill_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   lim_q;
	logic               cfg_wr;
	brf_item_t          head;
	logic               head_valid;
	logic               pop;

	function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (int'(v) > DEPTH) begin
			return CNT_W'(DEPTH);
		end
		return CNT_W'(v);
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32-LIMIT_W){1'b0}}, limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			lim_q   <= eff_limit(LIMIT_RESET);
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
			lim_q   <= eff_limit(pwdata[LIMIT_W-1:0]);
		end
	end

	brf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte_in (last_byte_in),
		.write_length (write_length),
		.take_length  (take_length),
		.lim          (lim_q),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	brf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim         (lim_q),
		.cfg_clear   (cfg_wr),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.strobe      (strobe),
		.status      (status),
		.out_byte    (out_byte),
		.last_result (last_result),
		.fill_count  (fill_count)
	);

endmodule
